// ===== rtl/msm_pkg.sv =====
package msm_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    localparam int FUNC_W     = 3;
    localparam int ID_IN_W    = 16;
    localparam int IDX_IN_W   = 4;
    localparam int FREE_OUT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEND  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RECV  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ALLOC,
        OP_FREE,
        OP_SEND,
        OP_RECV,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_OWNER = 2'd2,
        ST_NO_MSG    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [ID_IN_W-1:0]  req;
        logic [ID_IN_W-1:0]  tgt;
        logic [IDX_IN_W-1:0] idx;
        logic                idx_ok;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [IDX_IN_W-1:0]   slot;
        logic [FREE_OUT_W-1:0] free;
    } res_t;

endpackage

// ===== rtl/msm_front.sv =====
module msm_front #(
    parameter int SLOTS   = msm_pkg::SLOTS_DEF,
    parameter int ID_BITS = msm_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [msm_pkg::FUNC_W-1:0]    func,
    input  logic [msm_pkg::ID_IN_W-1:0]   requester_id,
    input  logic [msm_pkg::IDX_IN_W-1:0]  slot_index,
    input  logic [msm_pkg::ID_IN_W-1:0]   target_id,
    output logic                          cmd_valid,
    output msm_pkg::cmd_t                 cmd,
    input  logic                          cmd_take
);
    import msm_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = (SLOT_W > IDX_IN_W) ? SLOT_W : IDX_IN_W;
    localparam int KEEP_W = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;

    cmd_t             in_cmd;
    logic [IDX_W-1:0] idx_ext;
    logic             push_ok;

    cmd_t             q_mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign idx_ext = IDX_W'(slot_index);

    always_comb
    begin
        in_cmd.op = OP_NOP;
        case (func)
            FUNC_ALLOC: in_cmd.op = OP_ALLOC;
            FUNC_FREE:  in_cmd.op = OP_FREE;
            FUNC_SEND:  in_cmd.op = OP_SEND;
            FUNC_RECV:  in_cmd.op = OP_RECV;
            FUNC_CLEAR: in_cmd.op = OP_CLEAR;
            default:    in_cmd.op = OP_NOP;
        endcase
        in_cmd.req    = ID_IN_W'(requester_id[KEEP_W-1:0]);
        in_cmd.tgt    = ID_IN_W'(target_id[KEEP_W-1:0]);
        in_cmd.idx    = slot_index;
        in_cmd.idx_ok = (idx_ext <= IDX_W'(SLOTS - 1));
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push_ok   = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_take)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push_ok && !cmd_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push_ok && cmd_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/msm_engine.sv =====
module msm_engine #(
    parameter int SLOTS   = msm_pkg::SLOTS_DEF,
    parameter int ID_BITS = msm_pkg::ID_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  msm_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          res_valid,
    output msm_pkg::res_t res,
    input  logic          pop
);
    import msm_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = (SLOT_W > IDX_IN_W) ? SLOT_W : IDX_IN_W;
    localparam int KEEP_W = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;
    localparam int CNT_W  = ($clog2(SLOTS + 1) > FREE_OUT_W) ? $clog2(SLOTS + 1) : FREE_OUT_W;
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALLOC = 4'b0010,
        S_SEND  = 4'b0100,
        S_RECV  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cmd_t                cur_reg;
    cmd_t                cur_next;
    logic [SLOT_W-1:0]   pos_reg;
    logic [SLOT_W-1:0]   pos_next;
    logic [SLOTS-1:0]    owner_valid_reg;
    logic [SLOTS-1:0]    owner_valid_next;
    logic [SLOTS-1:0]    dest_valid_reg;
    logic [SLOTS-1:0]    dest_valid_next;
    logic [CNT_W-1:0]    free_reg;
    logic [CNT_W-1:0]    free_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    res_t                res_reg;
    res_t                res_next;

    logic [KEEP_W-1:0]   owner_mem [SLOTS];
    logic [KEEP_W-1:0]   dest_mem [SLOTS];
    logic [KEEP_W-1:0]   owner_q_reg;
    logic [KEEP_W-1:0]   dest_q_reg;
    logic                owner_we;
    logic [SLOT_W-1:0]   owner_waddr;
    logic [KEEP_W-1:0]   owner_wdata;
    logic                dest_we;
    logic [SLOT_W-1:0]   dest_waddr;
    logic [KEEP_W-1:0]   dest_wdata;
    logic [SLOT_W-1:0]   owner_raddr;
    logic [SLOT_W-1:0]   dest_raddr;

    logic [IDX_W-1:0]    cmd_idx_ext;
    logic [SLOT_W-1:0]   cmd_addr;
    logic [IDX_W-1:0]    cur_idx_ext;
    logic [SLOT_W-1:0]   cur_addr;
    logic                done;
    status_t             done_status;
    logic [SLOT_W-1:0]   done_slot;
    logic [IDX_W-1:0]    done_slot_ext;

    assign cmd_idx_ext   = IDX_W'(cmd.idx);
    assign cmd_addr      = cmd_idx_ext[SLOT_W-1:0];
    assign cur_idx_ext   = IDX_W'(cur_reg.idx);
    assign cur_addr      = cur_idx_ext[SLOT_W-1:0];
    assign done_slot_ext = IDX_W'(done_slot);

    assign owner_raddr = cmd.idx_ok ? cmd_addr : '0;
    assign dest_raddr  = (state_reg == S_RECV && pos_reg != LAST) ?
                         pos_reg + SLOT_W'(1) : '0;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        pos_next         = pos_reg;
        owner_valid_next = owner_valid_reg;
        dest_valid_next  = dest_valid_reg;
        free_next        = free_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;
        owner_we         = 1'b0;
        owner_waddr      = pos_reg;
        owner_wdata      = cur_reg.req[KEEP_W-1:0];
        dest_we          = 1'b0;
        dest_waddr       = cur_addr;
        dest_wdata       = cur_reg.tgt[KEEP_W-1:0];
        cmd_take         = 1'b0;
        done             = 1'b0;
        done_status      = ST_OK;
        done_slot        = '0;

        if (res_valid_reg && pop)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_take = 1'b1;
                    cur_next = cmd;
                    pos_next = '0;
                    case (cmd.op)
                        OP_ALLOC:
                        begin
                            state_next = S_ALLOC;
                        end
                        OP_RECV:
                        begin
                            state_next = S_RECV;
                        end
                        OP_SEND:
                        begin
                            if (cmd.idx_ok && owner_valid_reg[cmd_addr])
                            begin
                                state_next = S_SEND;
                            end
                            else
                            begin
                                done        = 1'b1;
                                done_status = ST_NOT_OWNER;
                            end
                        end
                        OP_FREE:
                        begin
                            if (cmd.idx_ok)
                            begin
                                if (owner_valid_reg[cmd_addr])
                                begin
                                    free_next = free_reg + CNT_W'(1);
                                end
                                owner_valid_next[cmd_addr] = 1'b0;
                                dest_valid_next[cmd_addr]  = 1'b0;
                            end
                            done = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            owner_valid_next = '0;
                            dest_valid_next  = '0;
                            free_next        = CNT_W'(SLOTS);
                            done             = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (!owner_valid_reg[pos_reg])
                begin
                    owner_we                  = 1'b1;
                    owner_valid_next[pos_reg] = 1'b1;
                    dest_valid_next[pos_reg]  = 1'b0;
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - CNT_W'(1);
                    end
                    done       = 1'b1;
                    done_slot  = pos_reg;
                    state_next = S_IDLE;
                end
                else if (pos_reg == LAST)
                begin
                    done        = 1'b1;
                    done_status = ST_NO_FREE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + SLOT_W'(1);
                end
            end
            S_SEND:
            begin
                if (owner_q_reg == cur_reg.req[KEEP_W-1:0])
                begin
                    dest_we                   = 1'b1;
                    dest_valid_next[cur_addr] = 1'b1;
                end
                else
                begin
                    done_status = ST_NOT_OWNER;
                end
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_RECV:
            begin
                if (dest_valid_reg[pos_reg] && dest_q_reg == cur_reg.req[KEEP_W-1:0])
                begin
                    done       = 1'b1;
                    done_slot  = pos_reg;
                    state_next = S_IDLE;
                end
                else if (pos_reg == LAST)
                begin
                    done        = 1'b1;
                    done_status = ST_NO_MSG;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            res_valid_next  = 1'b1;
            res_next.status = done_status;
            res_next.slot   = done_slot_ext[IDX_IN_W-1:0];
            res_next.free   = free_next[FREE_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            owner_valid_reg <= '0;
            dest_valid_reg  <= '0;
            free_reg        <= CNT_W'(SLOTS);
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            dest_valid_reg  <= dest_valid_next;
            free_reg        <= free_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[owner_waddr] <= owner_wdata;
        end
        owner_q_reg <= owner_mem[owner_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dest_we)
        begin
            dest_mem[dest_waddr] <= dest_wdata;
        end
        dest_q_reg <= dest_mem[dest_raddr];
    end

    // The free count always equals the number of slots without an owner.
    a_free_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~owner_valid_reg) == int'(free_reg))
        else $error("free count differs from the number of unowned slots");

    a_dest_needs_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (dest_valid_reg & ~owner_valid_reg) == '0)
        else $error("destination marked on a slot without an owner");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg != S_IDLE && res_valid_reg))
        else $error("operation in progress while a result is still pending");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && pop) |=> !res_valid_reg)
        else $error("result register not emptied after it was taken");

endmodule

// ===== rtl/message_slot_mailbox_unit.sv =====
// Free, clear and undefined codes are decided as the engine takes them from the request queue;
// send reads the slot owner through a registered memory read, then compares it; allocate and
// receive check one slot per cycle from slot zero to the first match. Results are registered.
// The engine starts a request only once the previous result is taken, so it cannot accept a
// new request while a result awaits pop; a two-entry request queue decouples the input.
// Reset empties the pool at once: all slots free, the request queue and result register empty.
module message_slot_mailbox_unit #(
    parameter int SLOTS   = msm_pkg::SLOTS_DEF,
    parameter int ID_BITS = msm_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [msm_pkg::FUNC_W-1:0]      func,
    input  logic [msm_pkg::ID_IN_W-1:0]     requester_id,
    input  logic [msm_pkg::IDX_IN_W-1:0]    slot_index,
    input  logic [msm_pkg::ID_IN_W-1:0]     target_id,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      status,
    output logic [msm_pkg::IDX_IN_W-1:0]    result_slot,
    output logic [msm_pkg::FREE_OUT_W-1:0]  free_count
);
    import msm_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    logic res_valid;
    res_t res;

    msm_front #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .requester_id (requester_id),
        .slot_index   (slot_index),
        .target_id    (target_id),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take)
    );

    msm_engine #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .pop       (pop)
    );

    assign empty       = !res_valid;
    assign status      = res.status;
    assign result_slot = res.slot;
    assign free_count  = res.free;

endmodule

// ===== dv/message_slot_mailbox_unit_tb.sv =====
module message_slot_mailbox_unit_tb;
    import msm_pkg::*;

    localparam int NUM_SLOTS   = SLOTS_DEF;
    localparam int RANDOM_REQS = 800;
    localparam int STALL_LIMIT = 2000;

    localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = FUNC_CLEAR + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

    localparam logic [ID_IN_W-1:0] ID_SET [6] = '{16'h0000, 16'hFFFF, 16'h0001,
                                                 16'h8000, 16'h5A5A, 16'h00FF};

    class mailbox_scoreboard;
        logic [ID_IN_W-1:0] owner_id [NUM_SLOTS];
        bit                 owner_valid [NUM_SLOTS];
        logic [ID_IN_W-1:0] dest_id [NUM_SLOTS];
        bit                 dest_valid [NUM_SLOTS];
        int unsigned        free_slots;
        res_t               pending_replies [$];
        int unsigned        error_count;
        int unsigned        request_count;
        int unsigned        reply_count;
        int unsigned        pool_full_count;
        int unsigned        not_owner_count;
        int unsigned        no_msg_count;
        int unsigned        recv_hit_count;

        function new();
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                owner_id[s]    = '0;
                owner_valid[s] = 1'b0;
                dest_id[s]     = '0;
                dest_valid[s]  = 1'b0;
            end
            free_slots = NUM_SLOTS;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            error_count++;
        endtask

        task note_request(input logic [FUNC_W-1:0] f, input logic [ID_IN_W-1:0] req,
                          input logic [IDX_IN_W-1:0] idx, input logic [ID_IN_W-1:0] tgt);
            res_t reply;
            reply.status = ST_OK;
            reply.slot   = '0;
            request_count++;
            case (f)
                FUNC_ALLOC:
                begin
                    reply.status = ST_NO_FREE;
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (!owner_valid[s])
                        begin
                            owner_id[s]    = req;
                            owner_valid[s] = 1'b1;
                            dest_valid[s]  = 1'b0;
                            if (free_slots > 0)
                            begin
                                free_slots--;
                            end
                            reply.status = ST_OK;
                            reply.slot   = IDX_IN_W'(s);
                            break;
                        end
                    end
                    if (reply.status == ST_NO_FREE)
                    begin
                        pool_full_count++;
                    end
                end
                FUNC_FREE:
                begin
                    if (int'(idx) < NUM_SLOTS)
                    begin
                        if (owner_valid[idx])
                        begin
                            free_slots++;
                        end
                        owner_valid[idx] = 1'b0;
                        dest_valid[idx]  = 1'b0;
                    end
                end
                FUNC_SEND:
                begin
                    if (int'(idx) < NUM_SLOTS && owner_valid[idx] && owner_id[idx] == req)
                    begin
                        dest_id[idx]    = tgt;
                        dest_valid[idx] = 1'b1;
                    end
                    else
                    begin
                        reply.status = ST_NOT_OWNER;
                        not_owner_count++;
                    end
                end
                FUNC_RECV:
                begin
                    reply.status = ST_NO_MSG;
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (dest_valid[s] && dest_id[s] == req)
                        begin
                            reply.status = ST_OK;
                            reply.slot   = IDX_IN_W'(s);
                            break;
                        end
                    end
                    if (reply.status == ST_OK)
                    begin
                        recv_hit_count++;
                    end
                    else
                    begin
                        no_msg_count++;
                    end
                end
                FUNC_CLEAR:
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        owner_valid[s] = 1'b0;
                        dest_valid[s]  = 1'b0;
                    end
                    free_slots = NUM_SLOTS;
                end
                default:
                begin
                end
            endcase
            reply.free = free_slots[FREE_OUT_W-1:0];
            pending_replies.push_back(reply);
        endtask

        task check_reply(input logic [1:0] got_status, input logic [IDX_IN_W-1:0] got_slot,
                         input logic [FREE_OUT_W-1:0] got_free);
            res_t want;
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                report($sformatf("reply %0d arrived with no request outstanding", reply_count));
                return;
            end
            want = pending_replies.pop_front();
            if (got_status !== want.status)
            begin
                report($sformatf("reply %0d status expected %0d, got %0d",
                                 reply_count, want.status, got_status));
            end
            if (got_slot !== want.slot)
            begin
                report($sformatf("reply %0d result_slot expected %0d, got %0d",
                                 reply_count, want.slot, got_slot));
            end
            if (got_free !== want.free)
            begin
                report($sformatf("reply %0d free_count expected %0d, got %0d",
                                 reply_count, want.free, got_free));
            end
        endtask

        task finish_check();
            while (pending_replies.size() != 0)
            begin
                void'(pending_replies.pop_front());
                report("a request never got its reply");
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [FUNC_W-1:0]     func;
    logic [ID_IN_W-1:0]    requester_id;
    logic [IDX_IN_W-1:0]   slot_index;
    logic [ID_IN_W-1:0]    target_id;
    logic                  empty;
    logic                  pop;
    logic [1:0]            status;
    logic [IDX_IN_W-1:0]   result_slot;
    logic [FREE_OUT_W-1:0] free_count;

    mailbox_scoreboard sb;
    int                pop_cycle = 0;
    int                stall_cycles = 0;

    message_slot_mailbox_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .requester_id (requester_id),
        .slot_index   (slot_index),
        .target_id    (target_id),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .result_slot  (result_slot),
        .free_count   (free_count)
    );

    always #5 clk = ~clk;

    function automatic logic [ID_IN_W-1:0] pick_id();
        if ($urandom_range(7, 0) == 0)
        begin
            return ID_IN_W'($urandom);
        end
        return ID_SET[$urandom_range(5, 0)];
    endfunction

    // Called just after a rising edge; returns just after the edge that takes the request.
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ID_IN_W-1:0] req,
                                input logic [IDX_IN_W-1:0] idx,
                                input logic [ID_IN_W-1:0] tgt);
        push         <= 1'b1;
        func         <= f;
        requester_id <= req;
        slot_index   <= idx;
        target_id    <= tgt;
        @(negedge clk);
        while (full)
        begin
            @(negedge clk);
        end
        sb.note_request(f, req, idx, tgt);
        @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_replies();
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pick_request(input int phase, output logic [FUNC_W-1:0] f,
                                output logic [ID_IN_W-1:0] req,
                                output logic [IDX_IN_W-1:0] idx,
                                output logic [ID_IN_W-1:0] tgt);
        int roll;
        int base;
        int s;
        int th [6];
        roll = $urandom_range(99, 0);
        base = $urandom_range(NUM_SLOTS - 1, 0);
        req  = pick_id();
        idx  = IDX_IN_W'($urandom);
        tgt  = pick_id();
        case (phase)
            0: th = '{25, 45, 65, 85, 89, 93};
            1: th = '{55, 70, 80, 84, 84, 86};
            default: th = '{15, 50, 80, 88, 90, 93};
        endcase
        if (roll < th[0])
        begin
            f = FUNC_ALLOC;
        end
        else if (roll < th[1])
        begin
            f = FUNC_SEND;
            if ($urandom_range(4, 0) != 0)
            begin
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    if (sb.owner_valid[(base + s) % NUM_SLOTS])
                    begin
                        idx = IDX_IN_W'((base + s) % NUM_SLOTS);
                        req = sb.owner_id[idx];
                        break;
                    end
                end
            end
        end
        else if (roll < th[2])
        begin
            f = FUNC_RECV;
            if ($urandom_range(1, 0) != 0)
            begin
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    if (sb.dest_valid[(base + s) % NUM_SLOTS])
                    begin
                        req = sb.dest_id[(base + s) % NUM_SLOTS];
                        break;
                    end
                end
            end
        end
        else if (roll < th[3])
        begin
            f = FUNC_FREE;
            if ($urandom_range(9, 0) < 7)
            begin
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    if (sb.owner_valid[(base + s) % NUM_SLOTS])
                    begin
                        idx = IDX_IN_W'((base + s) % NUM_SLOTS);
                        break;
                    end
                end
            end
        end
        else if (roll < th[4])
        begin
            f = FUNC_CLEAR;
        end
        else if (roll < th[5])
        begin
            f = FUNC_W'($urandom_range(FUNC_RSVD_HI, FUNC_RSVD_LO));
        end
        else
        begin
            f   = FUNC_W'($urandom);
            req = ID_IN_W'($urandom);
            tgt = ID_IN_W'($urandom);
        end
    endtask

    task automatic run_directed();
        send_request(FUNC_ALLOC, 16'hFFFF, 4'd0, 16'h0000);
        send_request(FUNC_ALLOC, 16'h0000, 4'd0, 16'h0000);
        send_request(FUNC_SEND, 16'hFFFF, 4'd0, 16'h0000);
        send_request(FUNC_SEND, 16'h0000, 4'd0, 16'h1234);
        send_request(FUNC_SEND, 16'h0000, 4'd9, 16'h0000);
        send_request(FUNC_SEND, 16'h0000, 4'd1, 16'hFFFF);
        send_request(FUNC_RECV, 16'h0000, 4'd0, 16'h0000);
        send_request(FUNC_RECV, 16'hFFFF, 4'd0, 16'h0000);
        send_request(FUNC_RECV, 16'h1234, 4'd0, 16'h0000);
        send_request(FUNC_FREE, 16'h0000, 4'd0, 16'h0000);
        send_request(FUNC_FREE, 16'h0000, 4'd0, 16'h0000);
        send_request(FUNC_RECV, 16'h0000, 4'd15, 16'h0000);
        for (int f = FUNC_RSVD_LO; f <= FUNC_RSVD_HI; f++)
        begin
            send_request(FUNC_W'(f), 16'hFFFF, 4'd15, 16'hFFFF);
        end
        send_request(FUNC_CLEAR, 16'hFFFF, 4'd15, 16'hFFFF);
        send_request(FUNC_ALLOC, 16'h0000, 4'd0, 16'h0000);
    endtask

    always @(posedge clk)
    begin
        pop_cycle <= pop_cycle + 1;
        case ((pop_cycle / 97) % 4)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(1, 0) != 0);
            2: pop <= ($urandom_range(3, 0) == 0);
            default: pop <= ((pop_cycle % 11) < 4);
        endcase
    end

    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_reply(status, result_slot, free_count);
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("message_slot_mailbox_unit_tb: errors");
        $finish;
    end

    initial
    begin
        logic [FUNC_W-1:0]   f;
        logic [ID_IN_W-1:0]  req;
        logic [IDX_IN_W-1:0] idx;
        logic [ID_IN_W-1:0]  tgt;
        int                  sent;
        int                  burst;
        bit                  paused;
        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        func         = '0;
        requester_id = '0;
        slot_index   = '0;
        target_id    = '0;
        sent         = 0;
        paused       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_replies();

        while (sent < RANDOM_REQS)
        begin
            burst = $urandom_range(12, 1);
            for (int k = 0; k < burst && sent < RANDOM_REQS; k++)
            begin
                pick_request((sent / 60) % 3, f, req, idx, tgt);
                send_request(f, req, idx, tgt);
                sent++;
            end
            if (!paused && sent >= RANDOM_REQS / 2)
            begin
                paused = 1'b1;
                wait_for_replies();
            end
            else if (((sent / 150) % 2) == 0)
            begin
                idle_sender($urandom_range(6, 0));
            end
        end

        wait_for_replies();
        repeat (NUM_SLOTS + 4) @(posedge clk);
        sb.finish_check();

        $display(
            "Covered %0d requests and %0d replies over all five functions and the undefined codes.",
            sb.request_count, sb.reply_count);
        $display("Pool full %0d, not owner %0d, receive hits %0d, no message %0d.",
                 sb.pool_full_count, sb.not_owner_count, sb.recv_hit_count, sb.no_msg_count);
        if (sb.error_count == 0)
        begin
            $display("message_slot_mailbox_unit_tb: clean");
        end
        else
        begin
            $display("message_slot_mailbox_unit_tb: errors");
        end
        $finish;
    end

endmodule
